>>> hdl/hcbp_pkg.sv
`default_nettype none
package hcbp_pkg;

   localparam int OP_W        = 2;
   localparam int SYM_W       = 8;
   localparam int CODE_W      = 32;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int PEND_W      = 7;
   localparam int PCNT_W      = 3;
   localparam int TABLE_DEPTH = 256;

   localparam int MAX_CODE_LEN_DEFAULT = 32;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   // item leaving the table stage toward the packer
   typedef struct packed {
      logic            valid;
      logic [OP_W-1:0] op;
      logic            hit;
   } item_type;

endpackage
`default_nettype wire

>>> hdl/hcbp_req_intf.sv
`default_nettype none
interface hcbp_req_intf;
   import hcbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [SYM_W-1:0]  symbol;
   logic [CODE_W-1:0] code_bits;
   logic [LEN_W-1:0]  code_length;

   modport source (output valid, operation, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, operation, symbol, code_bits, code_length, output ready);
endinterface
`default_nettype wire

>>> hdl/hcbp_rsp_intf.sv
`default_nettype none
interface hcbp_rsp_intf;
   import hcbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   logic              error;

   modport source (output valid, out_byte, last, error, input ready);
   modport sink   (input valid, out_byte, last, error, output ready);
endinterface
`default_nettype wire

>>> hdl/huffman_code_bit_packer_core.sv
`default_nettype none
// Huffman code table with an MSB-first bit packer. Load transactions write a
// code and its length into a 256-entry table RAM; encode transactions look the
// symbol up and emit every byte that its code completes, one result per cycle
// while the receiver is ready; flush transactions with bits pending emit the
// zero-padded last byte and then the count of its valid bits, marked last. An
// encode of a symbol that was never loaded returns one result with error set
// and leaves the packer untouched. Valid marks are flip-flops cleared by reset,
// so the block is ready right after reset with no clearing pass. Loads and
// unused codes never wait on the output; encodes and flushes wait until the
// result register (up to four bytes at a code length of 32) is free or is
// handing out its last byte. The registered table read is overlapped with the
// previous item's output, so items follow back to back while the receiver is ready.
module huffman_code_bit_packer_core #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   hcbp_req_intf.sink    req_bus,
   hcbp_rsp_intf.source  rsp_bus
);
   import hcbp_pkg::*;

   item_type                item;
   logic [MAX_CODE_LEN-1:0] item_code;
   logic [LEN_W-1:0]        item_len;
   logic                    item_take;

   hcbp_lookup #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .item      (item),
      .item_code (item_code),
      .item_len  (item_len),
      .item_take (item_take)
   );

   hcbp_packer #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .item_code (item_code),
      .item_len  (item_len),
      .item_take (item_take),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

>>> hdl/hcbp_ram.sv
`default_nettype none
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> hdl/hcbp_lookup.sv
`default_nettype none
module hcbp_lookup #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   hcbp_req_intf.sink                        req_bus,
   output hcbp_pkg::item_type                item,
   output logic [MAX_CODE_LEN-1:0]           item_code,
   output logic [hcbp_pkg::LEN_W-1:0]        item_len,
   input  wire logic                         item_take
);
   import hcbp_pkg::*;

   localparam int CW    = MAX_CODE_LEN;
   localparam int RAM_W = CW + LEN_W;

   logic              s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]   s1_op_ff;
   logic [SYM_W-1:0]  s1_sym_ff;
   logic [CW-1:0]     s1_code_ff, s1_code_in;
   logic [LEN_W-1:0]  s1_len_ff, s1_len_in;
   logic              fwd_ff, fwd_in;
   logic [CW-1:0]     fwd_code_ff;
   logic [LEN_W-1:0]  fwd_len_ff;
   logic [TABLE_DEPTH-1:0] vmark_ff, vmark_in;

   logic              accept;
   logic              stall;
   logic              load_fire;
   logic [SYM_W-1:0]  raddr;
   logic [RAM_W-1:0]  rdata;
   logic [LEN_W:0]    shamt;
   logic [CW+31:0]    code_ext;
   logic [CW+31:0]    code_shift;

   assign stall         = s1_valid_ff && !item_take;
   assign req_bus.ready = !s1_valid_ff || item_take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign load_fire     = s1_valid_ff && item_take && (s1_op_ff == OP_LOAD);

   // saturate the length and left-align the code so its first bit is the MSB
   always_comb begin
      if ({1'b0, req_bus.code_length} > (LEN_W+1)'(CW)) begin
         s1_len_in = LEN_W'(CW);
      end else begin
         s1_len_in = req_bus.code_length;
      end
      shamt      = (LEN_W+1)'(CW) - {1'b0, s1_len_in};
      code_ext   = {{CW{1'b0}}, req_bus.code_bits};
      code_shift = code_ext << shamt;
      s1_code_in = code_shift[CW-1:0];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (item_take) begin
         s1_valid_in = 1'b0;
      end
      fwd_in = fwd_ff;
      if (accept) begin
         fwd_in = load_fire && (s1_sym_ff == req_bus.symbol);
      end
      vmark_in = vmark_ff;
      if (load_fire) begin
         vmark_in[s1_sym_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         vmark_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
         vmark_ff    <= vmark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_bus.operation;
         s1_sym_ff   <= req_bus.symbol;
         s1_code_ff  <= s1_code_in;
         s1_len_ff   <= s1_len_in;
         fwd_code_ff <= s1_code_ff;
         fwd_len_ff  <= s1_len_ff;
      end
   end

   // hold the address while stalled so the read data stays put
   assign raddr = stall ? s1_sym_ff : req_bus.symbol;

   hcbp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (load_fire),
      .waddr (s1_sym_ff),
      .wdata ({s1_len_ff, s1_code_ff}),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      item.valid = s1_valid_ff;
      item.op    = s1_op_ff;
      item.hit   = vmark_ff[s1_sym_ff];
      if (fwd_ff) begin
         item_code = fwd_code_ff;
         item_len  = fwd_len_ff;
      end else begin
         item_code = rdata[CW-1:0];
         item_len  = rdata[RAM_W-1:CW];
      end
   end

endmodule
`default_nettype wire

>>> hdl/hcbp_packer.sv
`default_nettype none
module hcbp_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire hcbp_pkg::item_type           item,
   input  wire logic [MAX_CODE_LEN-1:0]      item_code,
   input  wire logic [hcbp_pkg::LEN_W-1:0]   item_len,
   output logic                              item_take,
   hcbp_rsp_intf.source                      rsp_bus
);
   import hcbp_pkg::*;

   localparam int CW      = MAX_CODE_LEN;
   localparam int WIN     = CW + BYTE_W;
   localparam int TOT_W   = LEN_W + 1;
   localparam int NB_W    = TOT_W - 3;
   localparam int EM_MAX  = ((CW + PEND_W) / BYTE_W > 2) ? (CW + PEND_W) / BYTE_W : 2;
   localparam int EC_W    = $clog2(EM_MAX + 1);

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [WIN-1:0]    em_shift_ff, em_shift_in;
   logic [EC_W-1:0]   em_cnt_ff, em_cnt_in;
   logic              em_last_ff, em_last_in;
   logic              em_err_ff, em_err_in;

   logic              em_free;
   logic              emit_op;
   logic              rsp_fire;
   logic [TOT_W-1:0]  total;
   logic [NB_W-1:0]   nbytes;
   logic [WIN-1:0]    comb_win;
   logic [WIN-1:0]    rest_win;
   logic [WIN-1:0]    flush_win;

   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign em_free  = (em_cnt_ff == '0) || ((em_cnt_ff == EC_W'(1)) && rsp_bus.ready);
   assign emit_op  = (item.op == OP_ENCODE) || (item.op == OP_FLUSH);
   assign item_take = item.valid && (!emit_op || em_free);

   // pending bits sit on top, the new code follows right behind them
   always_comb begin
      comb_win  = {pend_ff, 1'b0, {CW{1'b0}}} | ({item_code, {BYTE_W{1'b0}}} >> pcnt_ff);
      total     = {{(TOT_W-PCNT_W){1'b0}}, pcnt_ff} + {1'b0, item_len};
      nbytes    = total[TOT_W-1:3];
      rest_win  = comb_win << {nbytes, 3'b000};
      flush_win = WIN'({pend_ff, 1'b0, 5'b00000, pcnt_ff}) << (WIN - 2*BYTE_W);
   end

   always_comb begin
      pend_in     = pend_ff;
      pcnt_in     = pcnt_ff;
      em_shift_in = em_shift_ff;
      em_cnt_in   = em_cnt_ff;
      em_last_in  = em_last_ff;
      em_err_in   = em_err_ff;
      if (rsp_fire) begin
         em_shift_in = em_shift_ff << BYTE_W;
         em_cnt_in   = em_cnt_ff - EC_W'(1);
      end
      if (item_take) begin
         unique case (item.op)
            OP_ENCODE: begin
               if (!item.hit) begin
                  em_shift_in = '0;
                  em_cnt_in   = EC_W'(1);
                  em_last_in  = 1'b0;
                  em_err_in   = 1'b1;
               end else begin
                  pend_in     = rest_win[WIN-1 -: PEND_W];
                  pcnt_in     = total[PCNT_W-1:0];
                  em_shift_in = comb_win;
                  em_cnt_in   = EC_W'(nbytes);
                  em_last_in  = 1'b0;
                  em_err_in   = 1'b0;
               end
            end
            OP_FLUSH: begin
               if (pcnt_ff != '0) begin
                  pend_in     = '0;
                  pcnt_in     = '0;
                  em_shift_in = flush_win;
                  em_cnt_in   = EC_W'(2);
                  em_last_in  = 1'b1;
                  em_err_in   = 1'b0;
               end
            end
            default: begin
               // load and unused codes leave the packer alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         pcnt_ff   <= '0;
         em_cnt_ff <= '0;
      end else begin
         pend_ff   <= pend_in;
         pcnt_ff   <= pcnt_in;
         em_cnt_ff <= em_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      em_shift_ff <= em_shift_in;
      em_last_ff  <= em_last_in;
      em_err_ff   <= em_err_in;
   end

   assign rsp_bus.valid    = em_cnt_ff != '0;
   assign rsp_bus.out_byte = em_shift_ff[WIN-1 -: BYTE_W];
   assign rsp_bus.last     = em_last_ff && (em_cnt_ff == EC_W'(1));
   assign rsp_bus.error    = em_err_ff;

endmodule
`default_nettype wire

>>> dv/hcbp_packer_checker.sv
`default_nettype none
module hcbp_packer_checker #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   hcbp_req_intf     req_bus,
   hcbp_rsp_intf     rsp_bus,
   output int        mismatches,
   output int        bytes_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import hcbp_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
      logic              error;
   } exp_byte_type;

   logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
   logic [LEN_W-1:0]  len_tbl  [TABLE_DEPTH];
   logic              loaded   [TABLE_DEPTH];
   logic [PEND_W-1:0] held_bits;
   logic [PCNT_W-1:0] held_count;
   exp_byte_type      due_q [$];

   function automatic exp_byte_type make_byte(input logic [BYTE_W-1:0] b, input logic l,
                                              input logic e);
      exp_byte_type r;
      r.out_byte = b;
      r.last     = l;
      r.error    = e;
      return r;
   endfunction

   // shift the symbol's code into the held bits, first bit first; a miss queues an error byte
   task automatic pack_symbol(input logic [SYM_W-1:0] sym);
      logic [BYTE_W-1:0] acc;
      logic              b;
      int                cnt;
      int                pos;
      if (!loaded[sym]) begin
         due_q = {due_q, make_byte('0, 1'b0, 1'b1)};
         return;
      end
      acc = BYTE_W'(held_bits);
      cnt = int'(held_count);
      for (pos = int'(len_tbl[sym]) - 1; pos >= 0; pos--) begin
         b   = (pos < CODE_W) ? code_tbl[sym][pos] : 1'b0;
         acc = {acc[BYTE_W-2:0], b};
         cnt++;
         if (cnt == BYTE_W) begin
            due_q = {due_q, make_byte(acc, 1'b0, 1'b0)};
            cnt = 0;
            acc = '0;
         end
      end
      held_bits  = acc[PEND_W-1:0];
      held_count = PCNT_W'(cnt);
   endtask

   task automatic flush_held();
      logic [BYTE_W-1:0] pad;
      if (held_count == '0)
         return;
      pad = BYTE_W'(held_bits);
      pad = pad << (BYTE_W - int'(held_count));
      due_q = {due_q, make_byte(pad, 1'b0, 1'b0)};
      due_q = {due_q, make_byte(BYTE_W'(held_count), 1'b1, 1'b0)};
      held_bits  = '0;
      held_count = '0;
   endtask

   task automatic apply_item();
      logic [SYM_W-1:0] sym;
      sym = req_bus.symbol;
      case (req_bus.operation)
         OP_LOAD: begin
            code_tbl[sym] = req_bus.code_bits;
            len_tbl[sym]  = (int'(req_bus.code_length) > MAX_CODE_LEN) ?
                            LEN_W'(MAX_CODE_LEN) : req_bus.code_length;
            loaded[sym]   = 1'b1;
         end
         OP_ENCODE: pack_symbol(sym);
         OP_FLUSH:  flush_held();
         default: ;
      endcase
   endtask

   task automatic check_result();
      exp_byte_type exp_b;
      if (due_q.size() == 0) begin
         $display("%0t: unexpected result byte=%02h last=%0b error=%0b", $realtime,
                  rsp_bus.out_byte, rsp_bus.last, rsp_bus.error);
         mismatches++;
         return;
      end
      exp_b = due_q.pop_front();
      if (rsp_bus.out_byte !== exp_b.out_byte || rsp_bus.last !== exp_b.last ||
          rsp_bus.error !== exp_b.error) begin
         $display({"%0t: mismatch expected byte=%02h last=%0b error=%0b, ",
                   "got byte=%02h last=%0b error=%0b"},
                  $realtime, exp_b.out_byte, exp_b.last, exp_b.error,
                  rsp_bus.out_byte, rsp_bus.last, rsp_bus.error);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_q.delete();
         held_bits  = '0;
         held_count = '0;
         mismatches = 0;
         foreach (loaded[i])
            loaded[i] = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_result();
         if (req_bus.valid && req_bus.ready)
            apply_item();
      end
      bytes_due = due_q.size();
   end

endmodule
`default_nettype wire

>>> dv/tb_huffman_code_bit_packer_core.sv
`default_nettype none
module tb_huffman_code_bit_packer_core;
   import hcbp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 410;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   bytes_due;
   logic [7:0] stall_tick = '0;

   hcbp_req_intf req_if ();
   hcbp_rsp_intf rsp_if ();

   huffman_code_bit_packer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   hcbp_packer_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_if),
      .rsp_bus    (rsp_if),
      .mismatches (mismatches),
      .bytes_due  (bytes_due)
   );

   always #1 clock = ~clock;

   // receiver: cycle through free-running, light, heavy and periodic stalls
   always @(negedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      case (stall_tick[7:6])
         2'd0:    rsp_if.ready <= 1'b1;
         2'd1:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_if.ready <= ($urandom_range(0, 2) == 0);
         default: rsp_if.ready <= (stall_tick[2:0] < 3'd3);
      endcase
   end

   task automatic send(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                       input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.symbol      <= sym;
      req_if.code_bits   <= code;
      req_if.code_length <= len;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // drop valid and put junk on the payload
   task automatic pause(input int n);
      @(negedge clock);
      req_if.valid       <= 1'b0;
      req_if.operation   <= OP_W'($urandom());
      req_if.symbol      <= SYM_W'($urandom());
      req_if.code_bits   <= $urandom();
      req_if.code_length <= LEN_W'($urandom());
      repeat (n - 1) @(negedge clock);
   endtask

   initial begin
      #400_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [SYM_W-1:0]  loaded_syms [$];
      logic [SYM_W-1:0]  sym;
      logic [LEN_W-1:0]  len;
      int                burst_left;
      int                r;
      int                k;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.operation   = OP_LOAD;
      req_if.symbol      = '0;
      req_if.code_bits   = '0;
      req_if.code_length = '0;
      rsp_if.ready       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty flush, misses, unused op, full and empty codes, overlong length
      send(OP_FLUSH, 8'd0, '0, '0);
      send(OP_ENCODE, 8'd0, '0, '0);
      send(OP_ENCODE, 8'd255, '0, '0);
      send(OP_UNUSED, 8'd0, 32'hFFFF_FFFF, 6'd63);
      send(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
      send(OP_ENCODE, 8'd0, '0, '0);
      send(OP_LOAD, 8'd255, 32'h0000_0000, 6'd0);
      send(OP_ENCODE, 8'd255, '0, '0);
      send(OP_FLUSH, 8'd0, '0, '0);
      send(OP_LOAD, 8'd1, 32'h0000_0005, 6'd3);
      send(OP_ENCODE, 8'd1, '0, '0);
      send(OP_FLUSH, 8'd0, '0, '0);
      send(OP_LOAD, 8'd2, 32'hAAAA_AAAA, 6'd63);
      send(OP_ENCODE, 8'd2, '0, '0);
      send(OP_LOAD, 8'd3, 32'h0000_0001, 6'd1);
      for (k = 0; k < 7; k++)
         send(OP_ENCODE, 8'd3, '0, '0);
      send(OP_FLUSH, 8'd0, '0, '0);
      send(OP_LOAD, 8'd0, 32'h5555_0000, 6'd33);
      send(OP_ENCODE, 8'd0, '0, '0);
      send(OP_FLUSH, 8'd0, '0, '0);
      loaded_syms = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255};

      burst_left = 0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
               pause($urandom_range(1, 6));
         end
         burst_left--;
         // hold until every expected byte has drained
         if (k == RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            while (bytes_due != 0) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 14) begin
            sym = ($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, 255)) :
                                                SYM_W'($urandom_range(0, 31));
            case ($urandom_range(0, 9))
               0:       len = LEN_W'($urandom_range(0, 63));
               1:       len = 6'd32;
               default: len = LEN_W'($urandom_range(1, 12));
            endcase
            send(OP_LOAD, sym, $urandom(), len);
            loaded_syms = {loaded_syms, sym};
         end else if (r < 82) begin
            if ($urandom_range(0, 9) != 0)
               sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            else
               sym = SYM_W'($urandom_range(0, 255));
            send(OP_ENCODE, sym, $urandom(), LEN_W'($urandom()));
         end else if (r < 97) begin
            send(OP_FLUSH, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
         end else begin
            send(OP_UNUSED, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (bytes_due != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire
